// File: rtl/lobm_pkg.sv
// Order book matcher package: sizes, codes, book entry and control types.
// Used by lobm_book, limit_order_book_matcher and its checker.
package lobm_pkg;

    localparam int BOOK_DEPTH = 32;
    localparam int SIZE_BITS  = 24;
    localparam int ADDR_W     = $clog2(BOOK_DEPTH);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int SUM_W      = SIZE_BITS + CNT_W;
    localparam int AMT_W      = 29;
    localparam int LVL_W      = (CNT_W > 8) ? CNT_W : 8;
    localparam int NRES_W     = 7;
    localparam logic [NRES_W-1:0] MAX_RESULTS = 7'd64;
    localparam logic [AMT_W-1:0]  AMOUNT_MAX  = {AMT_W{1'b1}};

    // command codes
    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_CANCEL = 2'd1;
    localparam logic [1:0] CMD_DEPTH  = 2'd2;

    // result kinds
    localparam logic [2:0] KIND_ADDED     = 3'd0;
    localparam logic [2:0] KIND_REJECTED  = 3'd1;
    localparam logic [2:0] KIND_CANCELLED = 3'd2;
    localparam logic [2:0] KIND_NOT_FOUND = 3'd3;
    localparam logic [2:0] KIND_TRADE     = 3'd4;
    localparam logic [2:0] KIND_BID_LEVEL = 3'd5;
    localparam logic [2:0] KIND_ASK_LEVEL = 3'd6;
    localparam logic [2:0] KIND_EMPTY     = 3'd7;

    // book side operations
    localparam logic [1:0] BOP_NONE = 2'd0;
    localparam logic [1:0] BOP_INS  = 2'd1;
    localparam logic [1:0] BOP_REM  = 2'd2;
    localparam logic [1:0] BOP_SET0 = 2'd3;

    typedef struct packed {
        logic [31:0]          id;
        logic [31:0]          price;
        logic [SIZE_BITS-1:0] size;
    } entry_t;

    typedef struct packed {
        logic [1:0]        op;
        logic [ADDR_W-1:0] pos;
        entry_t            data;
    } book_ctl_t;

    // clamp a level sum to the amount field
    function automatic logic [AMT_W-1:0] sat_amount(input logic [SUM_W-1:0] v);
        logic [AMT_W-1:0] r;
        if (SUM_W > AMT_W && (v >> AMT_W) != '0)
            r = AMOUNT_MAX;
        else
            r = AMT_W'(v);
        return r;
    endfunction

endpackage

// File: rtl/lobm_book.sv
// One side of the order book: sorted entries with shift insert and remove.
// Depends on lobm_pkg.
module lobm_book
    import lobm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  book_ctl_t         ctl,
    input  logic [ADDR_W-1:0] rd_idx,
    output logic [CNT_W-1:0]  count,
    output entry_t            rd_entry,
    output entry_t            head
);

    entry_t            ent [BOOK_DEPTH];
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    // shift entries for insert and remove, update head size
    for (genvar g = 0; g < BOOK_DEPTH; g++) begin : g_ent
        always_ff @(posedge clk)
        begin
            unique case (ctl.op)
                BOP_INS:
                begin
                    if (ADDR_W'(g) == ctl.pos)
                        ent[g] <= ctl.data;
                    else if (g > 0 && ADDR_W'(g) > ctl.pos)
                        ent[g] <= ent[(g > 0) ? g - 1 : 0];
                end
                BOP_REM:
                begin
                    if (g < BOOK_DEPTH - 1 && ADDR_W'(g) >= ctl.pos)
                        ent[g] <= ent[(g < BOOK_DEPTH - 1) ? g + 1 : g];
                end
                BOP_SET0:
                begin
                    if (g == 0)
                        ent[g].size <= ctl.data.size;
                end
                default:
                begin
                end
            endcase
        end
    end

    // track fill count
    always_comb
    begin
        unique case (ctl.op)
            BOP_INS:  count_next = count_reg + CNT_W'(1);
            BOP_REM:  count_next = count_reg - CNT_W'(1);
            default:  count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    assign count    = count_reg;
    assign rd_entry = ent[rd_idx];
    assign head     = ent[0];

endmodule

// File: rtl/limit_order_book_matcher.sv
// Limit order book matcher top level: command sequencer over two book sides.
// Depends on lobm_pkg and lobm_book.
//
//   channel  | handshake         | fields
//   request  | start / busy      | command side price quantity cancel_id depth_levels
//   result   | strobe (1 cycle)  | kind order_id_res bid_order_id ask_order_id
//            |                   | level_price amount last
//
// One entry per cycle passes a shared compare step, except in steps that change sides
// or report a level. Add seeks the insert position, then trades while the book crosses;
// a rejected add ends at once; cancel searches bids then asks; depth walks the levels.
// Each result waits in a holding register until the next is made or the request ends;
// the final one shows in the first cycle with busy low.
// Reset clears the counts and sets the next id to one; the result side cannot stall.
module limit_order_book_matcher
    import lobm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           command,
    input  logic                 side,
    input  logic [31:0]          price,
    input  logic [23:0]          quantity,
    input  logic [31:0]          cancel_id,
    input  logic [7:0]           depth_levels,
    output logic                 strobe,
    output logic [2:0]           kind,
    output logic [31:0]          order_id_res,
    output logic [31:0]          bid_order_id,
    output logic [31:0]          ask_order_id,
    output logic [31:0]          level_price,
    output logic [AMT_W-1:0]     amount,
    output logic                 last
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_INS    = 3'd1;
    localparam logic [2:0] ST_CROSS  = 3'd2;
    localparam logic [2:0] ST_CANCEL = 3'd3;
    localparam logic [2:0] ST_DEPTH  = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    logic [2:0]           state_reg, state_next;
    logic                 side_reg, side_next;
    logic [31:0]          price_reg, price_next;
    logic [SIZE_BITS-1:0] qty_reg, qty_next;
    logic [31:0]          oid_reg, oid_next;
    logic [LVL_W-1:0]     levels_reg, levels_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic [CNT_W-1:0]     done_reg, done_next;
    logic [31:0]          cur_reg, cur_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic                 active_reg, active_next;
    logic [NRES_W-1:0]    n_reg, n_next;
    logic [31:0]          next_id_reg, next_id_next;

    logic                 pend_valid_reg, pend_valid_next;
    logic [2:0]           pend_kind_reg, pend_kind_next;
    logic [31:0]          pend_oid_reg, pend_oid_next;
    logic [31:0]          pend_bid_reg, pend_bid_next;
    logic [31:0]          pend_ask_reg, pend_ask_next;
    logic [31:0]          pend_price_reg, pend_price_next;
    logic [AMT_W-1:0]     pend_amt_reg, pend_amt_next;

    logic                 strobe_reg, strobe_next;
    logic                 last_reg, last_next;
    logic [2:0]           kind_reg, kind_next;
    logic [31:0]          oidr_reg, oidr_next;
    logic [31:0]          bidr_reg, bidr_next;
    logic [31:0]          askr_reg, askr_next;
    logic [31:0]          lprice_reg, lprice_next;
    logic [AMT_W-1:0]     amt_reg, amt_next;

    book_ctl_t            bid_ctl, ask_ctl;
    logic [CNT_W-1:0]     bid_cnt, ask_cnt;
    entry_t               bid_rd, ask_rd, bid_head, ask_head;

    // push request into the holding register
    logic                 push;
    logic [2:0]           p_kind;
    logic [31:0]          p_oid, p_bid, p_ask, p_price;
    logic [AMT_W-1:0]     p_amt;
    logic                 finish;

    // selected side for the scan step
    logic                 sel_side;
    logic [CNT_W-1:0]     sel_cnt;
    entry_t               sel_rd;
    logic                 in_range;
    logic [SIZE_BITS-1:0] match_size;
    logic                 crossed;

    lobm_book u_bid (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (bid_ctl),
        .rd_idx   (idx_reg[ADDR_W-1:0]),
        .count    (bid_cnt),
        .rd_entry (bid_rd),
        .head     (bid_head)
    );

    lobm_book u_ask (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ask_ctl),
        .rd_idx   (idx_reg[ADDR_W-1:0]),
        .count    (ask_cnt),
        .rd_entry (ask_rd),
        .head     (ask_head)
    );

    assign sel_side   = side_reg;
    assign sel_cnt    = sel_side ? ask_cnt : bid_cnt;
    assign sel_rd     = sel_side ? ask_rd : bid_rd;
    assign in_range   = idx_reg < sel_cnt;
    assign match_size = (bid_head.size < ask_head.size) ? bid_head.size : ask_head.size;
    assign crossed    = (n_reg < MAX_RESULTS) && (bid_cnt != '0) && (ask_cnt != '0)
                        && (bid_head.price >= ask_head.price);

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        side_next    = side_reg;
        price_next   = price_reg;
        qty_next     = qty_reg;
        oid_next     = oid_reg;
        levels_next  = levels_reg;
        idx_next     = idx_reg;
        done_next    = done_reg;
        cur_next     = cur_reg;
        sum_next     = sum_reg;
        active_next  = active_reg;
        next_id_next = next_id_reg;
        bid_ctl      = '0;
        ask_ctl      = '0;
        push         = 1'b0;
        finish       = 1'b0;
        p_kind       = KIND_ADDED;
        p_oid        = '0;
        p_bid        = '0;
        p_ask        = '0;
        p_price      = '0;
        p_amt        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    side_next   = (command == CMD_ADD) ? side : 1'b0;
                    price_next  = price;
                    qty_next    = SIZE_BITS'(quantity);
                    oid_next    = cancel_id;
                    levels_next = LVL_W'(depth_levels);
                    idx_next    = '0;
                    done_next   = '0;
                    active_next = 1'b0;
                    unique case (command)
                        CMD_ADD:
                        begin
                            if ((side ? ask_cnt : bid_cnt) == CNT_W'(BOOK_DEPTH))
                            begin
                                push       = 1'b1;
                                p_kind     = KIND_REJECTED;
                                state_next = ST_FINISH;
                            end
                            else
                                state_next = ST_INS;
                        end
                        CMD_CANCEL: state_next = ST_CANCEL;
                        CMD_DEPTH:  state_next = ST_DEPTH;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end

            // find insertion point, one entry per cycle
            ST_INS:
            begin
                if (!in_range || (side_reg ? (sel_rd.price > price_reg)
                                           : (sel_rd.price < price_reg)))
                begin
                    if (side_reg)
                    begin
                        ask_ctl.op   = BOP_INS;
                        ask_ctl.pos  = idx_reg[ADDR_W-1:0];
                        ask_ctl.data = '{id: next_id_reg, price: price_reg, size: qty_reg};
                    end
                    else
                    begin
                        bid_ctl.op   = BOP_INS;
                        bid_ctl.pos  = idx_reg[ADDR_W-1:0];
                        bid_ctl.data = '{id: next_id_reg, price: price_reg, size: qty_reg};
                    end
                    push         = 1'b1;
                    p_kind       = KIND_ADDED;
                    p_oid        = next_id_reg;
                    next_id_next = (next_id_reg == 32'hFFFF_FFFF) ? 32'd1
                                                                  : next_id_reg + 32'd1;
                    state_next   = ST_CROSS;
                end
                else
                    idx_next = idx_reg + CNT_W'(1);
            end

            // trade best bid against best ask
            ST_CROSS:
            begin
                if (crossed)
                begin
                    push    = 1'b1;
                    p_kind  = KIND_TRADE;
                    p_bid   = bid_head.id;
                    p_ask   = ask_head.id;
                    p_amt   = sat_amount(SUM_W'(match_size));
                    bid_ctl.op        = (bid_head.size == match_size) ? BOP_REM : BOP_SET0;
                    bid_ctl.data.size = bid_head.size - match_size;
                    ask_ctl.op        = (ask_head.size == match_size) ? BOP_REM : BOP_SET0;
                    ask_ctl.data.size = ask_head.size - match_size;
                end
                else
                    state_next = ST_FINISH;
            end

            // search bids then asks by id
            ST_CANCEL:
            begin
                if (in_range && sel_rd.id == oid_reg)
                begin
                    if (side_reg)
                    begin
                        ask_ctl.op  = BOP_REM;
                        ask_ctl.pos = idx_reg[ADDR_W-1:0];
                    end
                    else
                    begin
                        bid_ctl.op  = BOP_REM;
                        bid_ctl.pos = idx_reg[ADDR_W-1:0];
                    end
                    push       = 1'b1;
                    p_kind     = KIND_CANCELLED;
                    p_oid      = oid_reg;
                    state_next = ST_FINISH;
                end
                else if (in_range)
                    idx_next = idx_reg + CNT_W'(1);
                else if (!side_reg)
                begin
                    side_next = 1'b1;
                    idx_next  = '0;
                end
                else
                begin
                    push       = 1'b1;
                    p_kind     = KIND_NOT_FOUND;
                    p_oid      = oid_reg;
                    state_next = ST_FINISH;
                end
            end

            // aggregate price levels, bids then asks
            ST_DEPTH:
            begin
                if (active_reg)
                begin
                    if (in_range && sel_rd.price == cur_reg)
                    begin
                        sum_next = sum_reg + SUM_W'(sel_rd.size);
                        idx_next = idx_reg + CNT_W'(1);
                    end
                    else
                    begin
                        push        = 1'b1;
                        p_kind      = side_reg ? KIND_ASK_LEVEL : KIND_BID_LEVEL;
                        p_price     = cur_reg;
                        p_amt       = sat_amount(sum_reg);
                        done_next   = done_reg + CNT_W'(1);
                        active_next = 1'b0;
                    end
                end
                else if (in_range && LVL_W'(done_reg) < levels_reg)
                begin
                    cur_next    = sel_rd.price;
                    sum_next    = SUM_W'(sel_rd.size);
                    active_next = 1'b1;
                    idx_next    = idx_reg + CNT_W'(1);
                end
                else if (!side_reg)
                begin
                    side_next = 1'b1;
                    idx_next  = '0;
                    done_next = '0;
                end
                else
                begin
                    if (n_reg == '0)
                    begin
                        push   = 1'b1;
                        p_kind = KIND_EMPTY;
                    end
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                finish     = 1'b1;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // hold one result back so the final one can be flagged
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_kind_next  = pend_kind_reg;
        pend_oid_next   = pend_oid_reg;
        pend_bid_next   = pend_bid_reg;
        pend_ask_next   = pend_ask_reg;
        pend_price_next = pend_price_reg;
        pend_amt_next   = pend_amt_reg;
        n_next          = (state_reg == ST_IDLE) ? '0 : n_reg;
        strobe_next     = 1'b0;
        last_next       = 1'b0;
        kind_next       = pend_kind_reg;
        oidr_next       = pend_oid_reg;
        bidr_next       = pend_bid_reg;
        askr_next       = pend_ask_reg;
        lprice_next     = pend_price_reg;
        amt_next        = pend_amt_reg;

        if (push && (state_reg == ST_IDLE || n_reg < MAX_RESULTS))
        begin
            strobe_next     = pend_valid_reg;
            pend_valid_next = 1'b1;
            pend_kind_next  = p_kind;
            pend_oid_next   = p_oid;
            pend_bid_next   = p_bid;
            pend_ask_next   = p_ask;
            pend_price_next = p_price;
            pend_amt_next   = p_amt;
            n_next          = ((state_reg == ST_IDLE) ? '0 : n_reg) + NRES_W'(1);
        end
        else if (finish)
        begin
            strobe_next     = pend_valid_reg;
            last_next       = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            next_id_reg    <= 32'd1;
            pend_valid_reg <= 1'b0;
            strobe_reg     <= 1'b0;
            n_reg          <= '0;
            idx_reg        <= '0;
            done_reg       <= '0;
            active_reg     <= 1'b0;
            side_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            next_id_reg    <= next_id_next;
            pend_valid_reg <= pend_valid_next;
            strobe_reg     <= strobe_next;
            n_reg          <= n_next;
            idx_reg        <= idx_next;
            done_reg       <= done_next;
            active_reg     <= active_next;
            side_reg       <= side_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        price_reg      <= price_next;
        qty_reg        <= qty_next;
        oid_reg        <= oid_next;
        levels_reg     <= levels_next;
        cur_reg        <= cur_next;
        sum_reg        <= sum_next;
        pend_kind_reg  <= pend_kind_next;
        pend_oid_reg   <= pend_oid_next;
        pend_bid_reg   <= pend_bid_next;
        pend_ask_reg   <= pend_ask_next;
        pend_price_reg <= pend_price_next;
        pend_amt_reg   <= pend_amt_next;
        last_reg       <= last_next;
        kind_reg       <= kind_next;
        oidr_reg       <= oidr_next;
        bidr_reg       <= bidr_next;
        askr_reg       <= askr_next;
        lprice_reg     <= lprice_next;
        amt_reg        <= amt_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign strobe       = strobe_reg;
    assign kind         = kind_reg;
    assign order_id_res = oidr_reg;
    assign bid_order_id = bidr_reg;
    assign ask_order_id = askr_reg;
    assign level_price  = lprice_reg;
    assign amount       = amt_reg;
    assign last         = last_reg;

endmodule

// File: rtl/lobm_checker.sv
// Port-level checker for the order book matcher, bound to the top level.
// Depends on lobm_pkg.
module lobm_checker
    import lobm_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [1:0]  command,
    input logic        strobe,
    input logic [2:0]  kind,
    input logic [31:0] level_price,
    input logic        last
);

    // a result that is not final comes while the request is still in work
    a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |-> busy) else $error("non-final result while idle");

    // a real command keeps the block busy on the next cycle
    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (command == CMD_ADD || command == CMD_CANCEL
        || command == CMD_DEPTH) |=> busy) else $error("request not taken");

    // completion of a request shows the final result
    a_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> strobe && last) else $error("request ended without final result");

    // nothing follows the final result at once
    a_gap: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last |=> !strobe) else $error("result right after final");

    // trades carry no level price
    a_trade: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && kind == KIND_TRADE |-> level_price == '0) else $error("trade with price");

endmodule

bind limit_order_book_matcher lobm_checker u_lobm_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .command     (command),
    .strobe      (strobe),
    .kind        (kind),
    .level_price (level_price),
    .last        (last)
);
